// File: hw/rtl/gts_pkg.sv
// Package: shared codes and defaults for the green thread scheduler.
package gts_pkg;

  localparam int MAX_THREADS_DEF = 64;
  localparam logic [15:0] INTERVAL_RST = 16'd16;
  localparam logic [5:0] AWAIT_CNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    CMD_SPAWN  = 2'd0,
    CMD_YIELD  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_AWAIT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_BAD_TARGET = 2'd2,
    STAT_NO_RUN     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_WAITING = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

endpackage

// File: hw/rtl/gts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/gts_mod.sv
// Iterative 16-bit remainder unit, one quotient bit per cycle.
module gts_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] rem
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[15]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd16;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = 16'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[15:0];
      end
      dvd_nxt = {dvd_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// File: hw/rtl/green_thread_scheduler_core.sv
// Top level: green thread scheduler with slot table, ready FIFO and sequencer.
//
//   channel  | ports                               | flow
//   ---------+-------------------------------------+------------------------
//   in       | in_valid/in_ready, command, target  | one event per transaction
//   out      | out_valid/out_ready, six fields     | one result per event
//   cfg      | cfg_wr_en, cfg_wr_data              | starvation interval write
//
// Slot table: every access goes through the one read port of the slot RAM
// (a read state sets the address, the next state checks the registered
// data). Spawn probes the slots in order; a scheduler call (await first
// reads and counts its target) updates the current slot, waits on the
// remainder unit, runs the waiter scan when due, which reads the target of
// each waiting slot and wakes at most one, then dispatches and writes the
// result. Reset: a clearing pass writes every slot-table row; in_ready
// stays low until it finishes. A result waiting on out_ready holds the block
// in its final state; the next event is taken once that result has left.
module green_thread_scheduler_core #(
  parameter int MAX_THREADS = gts_pkg::MAX_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_new_id,
  output logic        out_dispatched,
  output logic [5:0]  out_running_id,
  output logic        out_woken_valid,
  output logic [5:0]  out_woken_id,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int SW   = $clog2(MAX_THREADS);
  localparam int CW   = SW + 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(MAX_THREADS - 1);
  localparam logic [CW-1:0] FIFO_CAP = CW'(MAX_THREADS);

  // one slot-table row
  typedef struct packed {
    logic              used;
    gts_pkg::mode_t    mode;
    logic [SW-1:0]     awaited;
    logic [5:0]        count;
    logic              queued;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [19:0] {
    S_CLR      = 20'h00001,
    S_IDLE     = 20'h00002,
    S_SP_RD    = 20'h00004,
    S_SP_CHK   = 20'h00008,
    S_TGT_RD   = 20'h00010,
    S_TGT_CHK  = 20'h00020,
    S_CUR_RD   = 20'h00040,
    S_CUR_UPD  = 20'h00080,
    S_MOD      = 20'h00100,
    S_SC_RD    = 20'h00200,
    S_SC_CHK   = 20'h00400,
    S_SC_TRD   = 20'h00800,
    S_SC_TCHK  = 20'h01000,
    S_SC_WAKE  = 20'h02000,
    S_DQ_RD    = 20'h04000,
    S_DQ_S     = 20'h08000,
    S_DQ_CHK   = 20'h10000,
    S_OLD_RD   = 20'h20000,
    S_OLD_CHK  = 20'h40000,
    S_FIN      = 20'h80000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  gts_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [5:0]       tgt_r, tgt_nxt;
  entry_t           word_r, word_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [SW-1:0]    head_r, head_nxt;
  logic [SW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [15:0]      cc_r, cc_nxt;
  logic [15:0]      intv_r, intv_nxt;
  gts_pkg::status_t status_r, status_nxt;
  logic [SW-1:0]    new_id_r, new_id_nxt;
  logic             disp_r, disp_nxt;
  logic             wv_r, wv_nxt;
  logic [SW-1:0]    wid_r, wid_nxt;

  logic             outv_r, outv_nxt;
  logic [1:0]       o_status_r, o_status_nxt;
  logic [5:0]       o_new_r, o_new_nxt;
  logic             o_disp_r, o_disp_nxt;
  logic [5:0]       o_run_r, o_run_nxt;
  logic             o_wv_r, o_wv_nxt;
  logic [5:0]       o_wid_r, o_wid_nxt;

  // slot table and ready FIFO ports
  logic             e_we;
  logic [SW-1:0]    e_waddr, e_raddr;
  entry_t           e_wdata, w;
  logic [EW-1:0]    e_rdata;
  logic             f_we;
  logic [SW-1:0]    f_rdata;

  logic             push_en;
  logic [SW-1:0]    push_id;
  logic             room;
  logic             mod_start, mod_busy;
  logic [15:0]      mod_rem;
  logic             out_free;

  gts_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_slot_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  gts_ram #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_fifo_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (tail_r),
    .wdata (push_id),
    .raddr (head_r),
    .rdata (f_rdata)
  );

  // call_counter % starvation_interval, worked out bit by bit
  gts_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (16'(cc_r + 16'd1)),
    .divisor  (intv_r),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  assign w        = entry_t'(e_rdata);
  assign room     = (cnt_r < FIFO_CAP);
  assign out_free = !outv_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    tgt_nxt    = tgt_r;
    word_nxt   = word_r;
    slot_nxt   = slot_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    cc_nxt     = cc_r;
    intv_nxt   = cfg_wr_en ? cfg_wr_data : intv_r;
    status_nxt = status_r;
    new_id_nxt = new_id_r;
    disp_nxt   = disp_r;
    wv_nxt     = wv_r;
    wid_nxt    = wid_r;
    e_we       = 1'b0;
    e_waddr    = idx_r;
    e_wdata    = w;
    e_raddr    = idx_r;
    push_en    = 1'b0;
    push_id    = idx_r;
    mod_start  = 1'b0;

    unique case (state_r)
      S_CLR: begin
        e_we    = 1'b1;
        e_waddr = idx_r;
        e_wdata = '0;
        if (idx_r == '0) begin
          e_wdata.used = 1'b1;
          e_wdata.mode = gts_pkg::MODE_RUNNING;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = gts_pkg::cmd_t'(in_command);
          tgt_nxt    = in_target_id;
          status_nxt = gts_pkg::STAT_OK;
          new_id_nxt = '0;
          disp_nxt   = 1'b0;
          wv_nxt     = 1'b0;
          wid_nxt    = '0;
          idx_nxt    = '0;
          unique case (gts_pkg::cmd_t'(in_command)) inside
            gts_pkg::CMD_SPAWN: state_nxt = S_SP_RD;
            gts_pkg::CMD_YIELD, gts_pkg::CMD_FINISH: state_nxt = S_CUR_RD;
            gts_pkg::CMD_AWAIT: begin
              if (32'(in_target_id) >= 32'(MAX_THREADS)) begin
                status_nxt = gts_pkg::STAT_BAD_TARGET;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_TGT_RD;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_SP_RD: begin
        e_raddr   = idx_r;
        state_nxt = S_SP_CHK;
      end

      S_SP_CHK: begin
        if (!w.used) begin
          e_wdata         = w;
          e_wdata.used    = 1'b1;
          e_wdata.mode    = gts_pkg::MODE_READY;
          e_wdata.awaited = '0;
          e_wdata.count   = '0;
          push_en         = !w.queued && room;
          push_id         = idx_r;
          e_wdata.queued  = w.queued || room;
          e_we            = 1'b1;
          e_waddr         = idx_r;
          new_id_nxt      = idx_r;
          state_nxt       = S_FIN;
        end else if (idx_r == LAST_IDX) begin
          status_nxt = gts_pkg::STAT_FULL;
          state_nxt  = S_FIN;
        end else begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_SP_RD;
        end
      end

      S_TGT_RD: begin
        e_raddr   = SW'(tgt_r);
        state_nxt = S_TGT_CHK;
      end

      S_TGT_CHK: begin
        if (!w.used) begin
          status_nxt = gts_pkg::STAT_BAD_TARGET;
          state_nxt  = S_FIN;
        end else begin
          e_wdata = w;
          if (w.count != gts_pkg::AWAIT_CNT_MAX) begin
            e_wdata.count = w.count + 6'd1;
          end
          e_we      = 1'b1;
          e_waddr   = SW'(tgt_r);
          state_nxt = S_CUR_RD;
        end
      end

      S_CUR_RD: begin
        e_raddr   = cur_r;
        state_nxt = S_CUR_UPD;
      end

      S_CUR_UPD: begin
        e_wdata = w;
        case (cmd_r)
          gts_pkg::CMD_YIELD: begin
            if (w.mode == gts_pkg::MODE_RUNNING) begin
              e_wdata.mode   = gts_pkg::MODE_READY;
              push_en        = !w.queued && room;
              push_id        = cur_r;
              e_wdata.queued = w.queued || room;
            end
          end
          gts_pkg::CMD_FINISH: e_wdata.mode = gts_pkg::MODE_DONE;
          gts_pkg::CMD_AWAIT: begin
            e_wdata.awaited = SW'(tgt_r);
            e_wdata.mode    = gts_pkg::MODE_WAITING;
          end
          default: e_wdata = w;
        endcase
        e_we      = 1'b1;
        e_waddr   = cur_r;
        cc_nxt    = cc_r + 16'd1;
        mod_start = 1'b1;
        state_nxt = S_MOD;
      end

      S_MOD: begin
        if (!mod_busy) begin
          idx_nxt = '0;
          if (cnt_r == '0 || (intv_r != '0 && mod_rem == '0)) begin
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_DQ_RD;
          end
        end
      end

      S_SC_RD: begin
        e_raddr   = idx_r;
        state_nxt = S_SC_CHK;
      end

      S_SC_CHK: begin
        word_nxt = w;
        if (w.used && w.mode == gts_pkg::MODE_WAITING) begin
          state_nxt = S_SC_TRD;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_DQ_RD;
        end else begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_SC_RD;
        end
      end

      S_SC_TRD: begin
        e_raddr   = word_r.awaited;
        state_nxt = S_SC_TCHK;
      end

      S_SC_TCHK: begin
        if (w.mode == gts_pkg::MODE_DONE) begin
          e_wdata = w;
          if (w.count != '0) begin
            e_wdata.count = w.count - 6'd1;
          end
          // last awaiter gone: release the target slot, queue mark stays
          if (e_wdata.count == '0) begin
            e_wdata.used    = 1'b0;
            e_wdata.mode    = gts_pkg::MODE_READY;
            e_wdata.awaited = '0;
          end
          e_we      = 1'b1;
          e_waddr   = word_r.awaited;
          wv_nxt    = 1'b1;
          wid_nxt   = idx_r;
          state_nxt = S_SC_WAKE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_DQ_RD;
        end else begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_SC_RD;
        end
      end

      S_SC_WAKE: begin
        e_wdata         = word_r;
        e_wdata.mode    = gts_pkg::MODE_READY;
        e_wdata.awaited = '0;
        push_en         = !word_r.queued && room;
        push_id         = idx_r;
        e_wdata.queued  = word_r.queued || room;
        e_we            = 1'b1;
        e_waddr         = idx_r;
        state_nxt       = S_DQ_RD;
      end

      S_DQ_RD: begin
        if (cnt_r == '0) begin
          status_nxt = gts_pkg::STAT_NO_RUN;
          state_nxt  = S_FIN;
        end else begin
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + SW'(1);
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DQ_S;
        end
      end

      S_DQ_S: begin
        slot_nxt  = f_rdata;
        e_raddr   = f_rdata;
        state_nxt = S_DQ_CHK;
      end

      S_DQ_CHK: begin
        e_wdata        = w;
        e_wdata.queued = 1'b0;
        e_we           = 1'b1;
        e_waddr        = slot_r;
        if (w.used && (w.mode == gts_pkg::MODE_READY ||
                       w.mode == gts_pkg::MODE_RUNNING)) begin
          e_wdata.mode = gts_pkg::MODE_RUNNING;
          cur_nxt      = slot_r;
          slot_nxt     = cur_r;
          status_nxt   = gts_pkg::STAT_OK;
          disp_nxt     = 1'b1;
          state_nxt    = (cur_r != slot_r) ? S_OLD_RD : S_FIN;
        end else begin
          status_nxt = gts_pkg::STAT_NO_RUN;
          state_nxt  = S_FIN;
        end
      end

      S_OLD_RD: begin
        e_raddr   = slot_r;
        state_nxt = S_OLD_CHK;
      end

      S_OLD_CHK: begin
        if (w.mode == gts_pkg::MODE_RUNNING) begin
          e_wdata        = w;
          e_wdata.mode   = gts_pkg::MODE_READY;
          push_en        = !w.queued && room;
          push_id        = slot_r;
          e_wdata.queued = w.queued || room;
          e_we           = 1'b1;
          e_waddr        = slot_r;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // push never shares a cycle with a pop
    f_we = push_en;
    if (push_en) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + SW'(1);
      cnt_nxt  = cnt_r + CW'(1);
    end
  end

  // output register
  always_comb begin
    outv_nxt     = outv_r && !out_ready;
    o_status_nxt = o_status_r;
    o_new_nxt    = o_new_r;
    o_disp_nxt   = o_disp_r;
    o_run_nxt    = o_run_r;
    o_wv_nxt     = o_wv_r;
    o_wid_nxt    = o_wid_r;
    if (state_r == S_FIN && out_free) begin
      outv_nxt     = 1'b1;
      o_status_nxt = status_r;
      o_new_nxt    = 6'(new_id_r);
      o_disp_nxt   = disp_r;
      o_run_nxt    = 6'(cur_r);
      o_wv_nxt     = wv_r;
      o_wid_nxt    = 6'(wid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
      cc_r    <= '0;
      intv_r  <= gts_pkg::INTERVAL_RST;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      cc_r    <= cc_nxt;
      intv_r  <= intv_nxt;
      outv_r  <= outv_nxt;
    end
    cmd_r      <= cmd_nxt;
    tgt_r      <= tgt_nxt;
    word_r     <= word_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    new_id_r   <= new_id_nxt;
    disp_r     <= disp_nxt;
    wv_r       <= wv_nxt;
    wid_r      <= wid_nxt;
    o_status_r <= o_status_nxt;
    o_new_r    <= o_new_nxt;
    o_disp_r   <= o_disp_nxt;
    o_run_r    <= o_run_nxt;
    o_wv_r     <= o_wv_nxt;
    o_wid_r    <= o_wid_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = outv_r;
  assign out_status      = o_status_r;
  assign out_new_id      = o_new_r;
  assign out_dispatched  = o_disp_r;
  assign out_running_id  = o_run_r;
  assign out_woken_valid = o_wv_r;
  assign out_woken_id    = o_wid_r;

endmodule

// File: hw/rtl/gts_chk.sv
// Port-level checker for the green thread scheduler, bound to the top level.
module gts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [5:0]  out_new_id,
  input logic        out_dispatched,
  input logic [5:0]  out_running_id,
  input logic        out_woken_valid,
  input logic [5:0]  out_woken_id
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_running_id) && $stable(out_woken_id))
    else $error("stalled result changed");

  // only a successful event may switch threads
  a_disp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dispatched |-> out_status == gts_pkg::STAT_OK)
    else $error("dispatch with error status");

  // new_id only on a successful spawn, which never dispatches
  a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_id != 6'd0 |->
      out_status == gts_pkg::STAT_OK && !out_dispatched && !out_woken_valid)
    else $error("new_id outside spawn");

  // woken_id is zero unless the scan woke a waiter
  a_woken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid |-> out_woken_id == 6'd0)
    else $error("woken_id without wake-up");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind green_thread_scheduler_core gts_chk u_gts_chk (.*);

// File: tb/sv/tb.sv
// Testbench for the green thread scheduler core: directed and random events.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int DRAIN_CYCLES = 4 * NSLOT + 40;    // worst event latency plus margin
  localparam int HOLD_CYCLES = 600;                // long receiver hold-off
  localparam int RANDOM_ITEMS = 930;

  // One scheduler result as seen on the out channel.
  typedef struct packed {
    gts_pkg::status_t status;
    logic [5:0]       new_id;
    logic             dispatched;
    logic [5:0]       running_id;
    logic             woken_valid;
    logic [5:0]       woken_id;
  } sched_result_t;

  // Holds the results still owed by the block and compares what comes out.
  class sched_scoreboard;
    sched_result_t owed[$];
    int errors = 0;

    function void note_event(sched_result_t r);
      owed.push_back(r);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(sched_result_t got);
      sched_result_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing pending, status", got.status, -1);
        return;
      end
      want = owed.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.new_id != want.new_id) report_mismatch("new_id", got.new_id, want.new_id);
      if (got.dispatched != want.dispatched)
        report_mismatch("dispatched", got.dispatched, want.dispatched);
      if (got.running_id != want.running_id)
        report_mismatch("running_id", got.running_id, want.running_id);
      if (got.woken_valid != want.woken_valid)
        report_mismatch("woken_valid", got.woken_valid, want.woken_valid);
      if (got.woken_id != want.woken_id)
        report_mismatch("woken_id", got.woken_id, want.woken_id);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = gts_pkg::CMD_SPAWN;
  logic [5:0]  in_target_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_new_id;
  logic        out_dispatched;
  logic [5:0]  out_running_id;
  logic        out_woken_valid;
  logic [5:0]  out_woken_id;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  green_thread_scheduler_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_target_id   (in_target_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_new_id     (out_new_id),
    .out_dispatched (out_dispatched),
    .out_running_id (out_running_id),
    .out_woken_valid(out_woken_valid),
    .out_woken_id   (out_woken_id),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #10 clk = ~clk;

  sched_scoreboard sb = new();

  // Idle rates in percent, changed per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: slot table, ready ring and call counter kept in step with the block.
  // ---------------------------------------------------------------------------
  logic             slot_live[NSLOT];
  gts_pkg::mode_t   slot_state[NSLOT];
  logic [5:0]       wait_target[NSLOT];
  logic [5:0]       waiter_cnt[NSLOT];
  logic             in_ring[NSLOT];
  logic [5:0]       ring[NSLOT];
  int               ring_head, ring_tail, ring_fill;
  logic [5:0]       running_slot;
  logic [15:0]      sched_calls;
  logic [15:0]      scan_interval;

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0;
      slot_state[i] = gts_pkg::MODE_READY;
      wait_target[i] = '0;
      waiter_cnt[i] = '0;
      in_ring[i] = 1'b0;
      ring[i] = '0;
    end
    slot_live[0] = 1'b1;
    slot_state[0] = gts_pkg::MODE_RUNNING;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    running_slot = '0;
    sched_calls = '0;
    scan_interval = gts_pkg::INTERVAL_RST;
  endfunction

  function automatic void enqueue_slot(int s);
    if (in_ring[s] || ring_fill >= NSLOT) return;
    in_ring[s] = 1'b1;
    ring[ring_tail] = s[5:0];
    ring_tail = (ring_tail + 1) % NSLOT;
    ring_fill++;
  endfunction

  function automatic int dequeue_slot();
    int s;
    s = ring[ring_head];
    ring_head = (ring_head + 1) % NSLOT;
    ring_fill--;
    in_ring[s] = 1'b0;
    return s;
  endfunction

  // One scheduler call: optional waiter scan, then dispatch of the ring head.
  function automatic void run_scheduler(ref sched_result_t r);
    bit do_scan;
    int t, s, prev;
    sched_calls = sched_calls + 16'd1;
    do_scan = (ring_fill == 0) ||
              (scan_interval != 0 && (sched_calls % scan_interval) == 0);
    if (do_scan) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!slot_live[i] || slot_state[i] != gts_pkg::MODE_WAITING) continue;
        t = wait_target[i];
        if (slot_state[t] != gts_pkg::MODE_DONE) continue;
        if (waiter_cnt[t] > 0) waiter_cnt[t]--;
        if (waiter_cnt[t] == 0) begin
          // last waiter gone: target slot returns to the free pool
          slot_live[t] = 1'b0;
          slot_state[t] = gts_pkg::MODE_READY;
          wait_target[t] = '0;
          waiter_cnt[t] = '0;
        end
        slot_state[i] = gts_pkg::MODE_READY;
        wait_target[i] = '0;
        enqueue_slot(i);
        r.woken_valid = 1'b1;
        r.woken_id = i[5:0];
        break;
      end
    end
    r.status = gts_pkg::STAT_NO_RUN;
    if (ring_fill != 0) begin
      s = dequeue_slot();
      // stale entries (freed, waiting or done) are simply dropped
      if (slot_live[s] && (slot_state[s] == gts_pkg::MODE_READY ||
                           slot_state[s] == gts_pkg::MODE_RUNNING)) begin
        prev = running_slot;
        running_slot = s[5:0];
        if (slot_state[prev] == gts_pkg::MODE_RUNNING && prev != s) begin
          slot_state[prev] = gts_pkg::MODE_READY;
          enqueue_slot(prev);
        end
        slot_state[s] = gts_pkg::MODE_RUNNING;
        r.status = gts_pkg::STAT_OK;
        r.dispatched = 1'b1;
      end
    end
  endfunction

  function automatic sched_result_t predict_event(gts_pkg::cmd_t cmd, logic [5:0] tgt);
    sched_result_t r;
    int cur, s;
    r = '0;
    cur = running_slot;
    case (cmd)
      gts_pkg::CMD_SPAWN: begin
        s = NSLOT;
        for (int i = 0; i < NSLOT; i++) begin
          if (!slot_live[i]) begin
            s = i;
            break;
          end
        end
        if (s == NSLOT) begin
          r.status = gts_pkg::STAT_FULL;
        end else begin
          slot_live[s] = 1'b1;
          slot_state[s] = gts_pkg::MODE_READY;
          wait_target[s] = '0;
          waiter_cnt[s] = '0;
          enqueue_slot(s);
          r.new_id = s[5:0];
        end
      end
      gts_pkg::CMD_YIELD: begin
        if (slot_state[cur] == gts_pkg::MODE_RUNNING) begin
          slot_state[cur] = gts_pkg::MODE_READY;
          enqueue_slot(cur);
        end
        run_scheduler(r);
      end
      gts_pkg::CMD_FINISH: begin
        slot_state[cur] = gts_pkg::MODE_DONE;
        run_scheduler(r);
      end
      default: begin
        if (!slot_live[tgt]) begin
          r.status = gts_pkg::STAT_BAD_TARGET;
        end else begin
          if (waiter_cnt[tgt] < gts_pkg::AWAIT_CNT_MAX) waiter_cnt[tgt]++;
          wait_target[cur] = tgt;
          slot_state[cur] = gts_pkg::MODE_WAITING;
          run_scheduler(r);
        end
      end
    endcase
    r.running_id = running_slot;
    return r;
  endfunction

  // Picks a live slot to await, or any slot when none is live.
  function automatic logic [5:0] live_target();
    int live[$];
    for (int i = 0; i < NSLOT; i++) if (slot_live[i]) live.push_back(i);
    if (live.size() == 0) return 6'($urandom_range(0, NSLOT - 1));
    return 6'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Entry and exit of each task are at a falling edge.
  // ---------------------------------------------------------------------------
  task send_event(gts_pkg::cmd_t cmd, logic [5:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_target_id <= tgt;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    // transaction accepted at this edge
    sb.note_event(predict_event(cmd, tgt));
    @(negedge clk);
  endtask

  // Waits until every owed result has arrived, then lets the block settle.
  task wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_interval(logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    scan_interval = value;
    @(negedge clk);
  endtask

  // Random event: mostly a well-formed mix of spawn/yield/finish/await,
  // now and then a spawn burst that fills the table.
  task automatic random_event(ref int sent);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      repeat (NSLOT + 4) begin
        send_event(gts_pkg::CMD_SPAWN, 6'($urandom_range(0, 63)));
        sent++;
      end
    end else if (pick < 30) begin
      send_event(gts_pkg::CMD_SPAWN, 6'($urandom_range(0, 63)));
      sent++;
    end else if (pick < 60) begin
      send_event(gts_pkg::CMD_YIELD, 6'($urandom_range(0, 63)));
      sent++;
    end else if (pick < 75) begin
      send_event(gts_pkg::CMD_FINISH, 6'($urandom_range(0, 63)));
      sent++;
    end else if (pick < 93) begin
      send_event(gts_pkg::CMD_AWAIT, live_target());
      sent++;
    end else begin
      // random target, often unused
      send_event(gts_pkg::CMD_AWAIT, 6'($urandom_range(0, 63)));
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{status: gts_pkg::status_t'(out_status), new_id: out_new_id,
                        dispatched: out_dispatched, running_id: out_running_id,
                        woken_valid: out_woken_valid, woken_id: out_woken_id});
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    clear_table();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset interval, every command, bad targets, done targets.
    send_event(gts_pkg::CMD_YIELD, 6'd0);      // main thread requeued and dispatched again
    send_event(gts_pkg::CMD_AWAIT, 6'd63);     // unused target
    send_event(gts_pkg::CMD_SPAWN, 6'd63);
    send_event(gts_pkg::CMD_SPAWN, 6'd0);
    send_event(gts_pkg::CMD_SPAWN, 6'd21);
    send_event(gts_pkg::CMD_YIELD, 6'd42);
    send_event(gts_pkg::CMD_YIELD, 6'd0);
    send_event(gts_pkg::CMD_AWAIT, 6'd2);      // park current on slot 2
    send_event(gts_pkg::CMD_AWAIT, 6'd0);      // possibly a self await
    send_event(gts_pkg::CMD_FINISH, 6'd0);
    send_event(gts_pkg::CMD_YIELD, 6'd0);      // current may not be running
    send_event(gts_pkg::CMD_FINISH, 6'd0);
    send_event(gts_pkg::CMD_FINISH, 6'd0);     // queue drained, scan runs and wakes no waiter
    send_event(gts_pkg::CMD_YIELD, 6'd0);
    send_event(gts_pkg::CMD_SPAWN, 6'd0);
    send_event(gts_pkg::CMD_AWAIT, 6'd1);
    send_event(gts_pkg::CMD_FINISH, 6'd63);
    send_event(gts_pkg::CMD_YIELD, 6'd0);
    send_event(gts_pkg::CMD_AWAIT, 6'd40);
    send_event(gts_pkg::CMD_SPAWN, 6'd0);
    wait_drained();

    // Phase 1: scan on every call, sender idles a third, receiver mostly stalls.
    write_interval(16'd1);
    send_idle_pct = 34;
    recv_idle_pct = 74;
    hold_request = 1'b1;              // block fills and backs up the input
    sent = 0;
    while (sent < RANDOM_ITEMS / 3) random_event(sent);
    wait_drained();

    // Phase 2: largest interval, roles of the idlers swapped.
    write_interval(16'hFFFF);
    send_idle_pct = 74;
    recv_idle_pct = 34;
    sent = 0;
    while (sent < RANDOM_ITEMS / 6) random_event(sent);
    // sender pauses until the block has caught up
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    sent = 0;
    while (sent < RANDOM_ITEMS / 6) random_event(sent);
    wait_drained();

    // Phase 3: no idling; zero interval, then a random one.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_interval(16'd0);
    sent = 0;
    while (sent < RANDOM_ITEMS / 6) random_event(sent);
    wait_drained();
    write_interval(16'($urandom_range(2, 40)));
    sent = 0;
    while (sent < RANDOM_ITEMS / 6) random_event(sent);
    wait_drained();

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
